// File: sv/bpsa_pkg.sv
// Shared codes and field widths of the bitmap page span allocator.
package bpsa_pkg;

   localparam int DEF_WORD_COUNT = 8;
   localparam int DEF_WORD_BITS  = 64;

   localparam int REQ_W    = 2;
   localparam int SPAN_W   = 7;
   localparam int PAGE_W   = 9;
   localparam int STATUS_W = 3;
   localparam int CFG_W    = 10;

   typedef enum logic [REQ_W-1:0] {
      REQ_INIT  = 2'd0,
      REQ_ALLOC = 2'd1,
      REQ_FREE  = 2'd2
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 3'd0,
      ST_NO_ROOM   = 3'd1,
      ST_RETIRED   = 3'd2,
      ST_FREED     = 3'd3,
      ST_NO_HEADER = 3'd4
   } status_type;

endpackage

// File: sv/bpsa_ram.sv
// Generic one-write, one-read RAM with registered read data.
module bpsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/bpsa_fit.sv
// Shared search unit: lowest position where a run of len clear bits fits in one word.
module bpsa_fit #(
   parameter int WORD_BITS = 64,
   localparam int NB = $clog2(WORD_BITS + 1),
   localparam int PB = $clog2(WORD_BITS)
) (
   input  logic [WORD_BITS-1:0] vec,
   input  logic [NB-1:0]        len,
   output logic                 found,
   output logic [PB-1:0]        pos
);

   localparam int SW = NB + 1;
   localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

   logic [WORD_BITS-1:0] len_mask;
   logic [WORD_BITS-1:0] ok;
   logic [WORD_BITS-1:0] first;

   assign len_mask = ~(ALL_ONES << len);

   // Each candidate start is judged on its own: run clear and inside the word.
   always_comb begin
      for (int p = 0; p < WORD_BITS; p++) begin
         ok[p] = (((vec >> p) & len_mask) == '0) &&
                 (({1'b0, len} + SW'(p)) <= SW'(WORD_BITS));
      end
   end

   // Keep only the lowest candidate, then encode it.
   assign first = ok & (~ok + WORD_BITS'(1));
   assign found = |ok;

   always_comb begin
      pos = '0;
      for (int p = 0; p < WORD_BITS; p++) begin
         if (first[p]) begin
            pos = pos | PB'(p);
         end
      end
   end

endmodule

// File: sv/bitmap_page_span_allocator.sv
// Top level of the bitmap page span allocator: sequencer, word stores and result register.
// Init writes one word per cycle; allocate searches one occupancy word per cycle with the shared
// fit unit, but a size outside 1 to WORD_BITS, like an unknown code, is answered straight from idle.
// Free divides, reads and evaluates the page's word; a page past the region is answered before the
// read, and a free that empties the whole region retires it. One request at a time; for requests that
// leave idle, busy stays high until the result strobe. After reset a clearing pass zeroes both
// bitmaps with busy high; the receiver cannot stall.
module bitmap_page_span_allocator import bpsa_pkg::*; #(
   parameter int WORD_COUNT = DEF_WORD_COUNT,
   parameter int WORD_BITS  = DEF_WORD_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [REQ_W-1:0]    req_type,
   input  logic [SPAN_W-1:0]   req_span_pages,
   input  logic [PAGE_W-1:0]   req_page_index,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [PAGE_W-1:0]   rsp_page_out,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CFG_W-1:0]    csr_data
);

   // Word index, run length and bit position widths.
   localparam int AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int NB    = $clog2(WORD_BITS + 1);
   localparam int PB    = $clog2(WORD_BITS);
   localparam int PO_W  = AW + NB + PAGE_W;
   localparam int REM_W = PAGE_W + NB;

   // The word of a page comes from a multiply by a rounded-up reciprocal. With
   // page * WORD_BITS below 2**SHIFT the quotient is exact, so no correction is needed.
   localparam int SHIFT   = PAGE_W + NB;
   localparam int RECIP   = ((2 ** SHIFT) + WORD_BITS - 1) / WORD_BITS;
   localparam int RECIP_W = SHIFT + 1;
   localparam int PROD_W  = PAGE_W + RECIP_W;

   localparam logic [WORD_BITS-1:0] ALL_ONES = '1;
   localparam logic [WORD_BITS-1:0] ONE_BIT  = WORD_BITS'(1);

   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_INIT  = 10'b0000000100,
      S_ASCAN = 10'b0000001000,
      S_FDIV  = 10'b0000010000,
      S_FREAD = 10'b0000100000,
      S_FEVAL = 10'b0001000000,
      S_FCHK  = 10'b0010000000,
      S_FCMP  = 10'b0100000000,
      S_FFILL = 10'b1000000000
   } state_type;

   // Control registers.
   state_type         state_ff, state_in;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic [CFG_W-1:0]  reserved_ff, reserved_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [CFG_W-1:0]  left_ff, left_in;
   logic [SPAN_W-1:0] n_ff, n_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [PAGE_W-1:0] q_ff, q_in;
   logic [PB-1:0]     pos_ff, pos_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0] rsp_page_out_ff, rsp_page_out_in;

   // Store ports.
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        wr_addr;
   logic                 occ_we, hdr_we;
   logic [WORD_BITS-1:0] occ_wdata, hdr_wdata;
   logic [WORD_BITS-1:0] occ_rd, hdr_rd;

   // Shared fit unit.
   logic [WORD_BITS-1:0] fit_vec;
   logic [NB-1:0]        fit_len;
   logic                 fit_found;
   logic [PB-1:0]        fit_pos;

   // Helpers.
   logic                 cnt_last;
   logic [NB-1:0]        take;
   logic [NB-1:0]        n_clip;
   logic [PB-1:0]        hpos;
   logic                 hdr_hit;
   logic [WORD_BITS-1:0] freed_occ;
   logic [PROD_W-1:0]    quot_prod;
   logic [REM_W-1:0]     rem_full;
   logic [PO_W-1:0]      alloc_page;
   logic [PO_W-1:0]      free_page;

   assign cnt_last = (cnt_ff == AW'(WORD_COUNT - 1));

   // Pages reserved in the current init word: whatever is left, at most one word.
   assign take = (left_ff > CFG_W'(WORD_BITS)) ? NB'(WORD_BITS) : left_ff[NB-1:0];

   // A free longer than a word is trimmed to a word; bits past the word's top drop out.
   assign n_clip = (n_ff > SPAN_W'(WORD_BITS)) ? NB'(WORD_BITS) : n_ff[NB-1:0];

   // Page zero is always its own span header, whatever the header bitmap says.
   assign hdr_hit   = (page_ff == '0) || fit_found;
   assign hpos      = (page_ff == '0) ? '0 : fit_pos;
   assign freed_occ = occ_rd & ~((~(ALL_ONES << n_clip)) << hpos);

   assign quot_prod = PROD_W'(page_ff) * PROD_W'(RECIP);
   assign rem_full  = REM_W'(page_ff) - (REM_W'(q_ff) * REM_W'(WORD_BITS));

   assign alloc_page = (PO_W'(cnt_ff) * PO_W'(WORD_BITS)) + PO_W'(fit_pos);
   assign free_page  = (PO_W'(q_ff[AW-1:0]) * PO_W'(WORD_BITS)) + PO_W'(hpos);

   bpsa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_COUNT)
   ) u_occ_ram (
      .clock   (clock),
      .wr_en   (occ_we),
      .wr_addr (wr_addr),
      .wr_data (occ_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (occ_rd)
   );

   bpsa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_COUNT)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (hdr_we),
      .wr_addr (wr_addr),
      .wr_data (hdr_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (hdr_rd)
   );

   // On allocate the unit looks for a clear run of n pages in the occupancy word.
   // On free it looks for the first set header bit at or above the page's position,
   // which is the first clear bit of the inverted, masked header word.
   always_comb begin
      fit_vec = occ_rd;
      fit_len = n_ff[NB-1:0];
      if (state_ff == S_FEVAL) begin
         fit_vec = ~(hdr_rd & (ALL_ONES << pos_ff));
         fit_len = NB'(1);
      end
   end

   bpsa_fit #(
      .WORD_BITS (WORD_BITS)
   ) u_fit (
      .vec   (fit_vec),
      .len   (fit_len),
      .found (fit_found),
      .pos   (fit_pos)
   );

   // Sequencer.
   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      left_in         = left_ff;
      n_in            = n_ff;
      page_in         = page_ff;
      q_in            = q_ff;
      pos_in          = pos_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_page_out_in = rsp_page_out_ff;
      rd_en           = 1'b0;
      rd_addr         = cnt_ff;
      wr_addr         = cnt_ff;
      occ_we          = 1'b0;
      hdr_we          = 1'b0;
      occ_wdata       = '0;
      hdr_wdata       = '0;

      unique case (state_ff)
         // Zero both bitmaps, one word per cycle, after reset.
         S_CLEAR: begin
            occ_we = 1'b1;
            hdr_we = 1'b1;
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end

         S_IDLE: begin
            if (start) begin
               n_in    = req_span_pages;
               page_in = req_page_index;
               cnt_in  = '0;
               unique case (req_code_type'(req_type))
                  REQ_INIT: begin
                     left_in  = reserved_ff;
                     state_in = S_INIT;
                  end
                  REQ_ALLOC: begin
                     if ((req_span_pages == '0) ||
                         (req_span_pages > SPAN_W'(WORD_BITS))) begin
                        rsp_valid_in    = 1'b1;
                        rsp_status_in   = ST_NO_ROOM;
                        rsp_page_out_in = '0;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = S_ASCAN;
                     end
                  end
                  REQ_FREE: begin
                     state_in = S_FDIV;
                  end
                  default: begin
                     // Unknown request: nothing changes.
                     rsp_valid_in    = 1'b1;
                     rsp_status_in   = ST_DONE;
                     rsp_page_out_in = '0;
                  end
               endcase
            end
         end

         // Leading pages reserved, the rest free, no headers.
         S_INIT: begin
            occ_we    = 1'b1;
            hdr_we    = 1'b1;
            occ_wdata = ~(ALL_ONES << take);
            left_in   = left_ff - CFG_W'(take);
            if (cnt_last) begin
               cnt_in          = '0;
               rsp_valid_in    = 1'b1;
               rsp_status_in   = ST_DONE;
               rsp_page_out_in = '0;
               state_in        = S_IDLE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end

         // Word cnt_ff is on the read ports; the next one is fetched on a miss.
         S_ASCAN: begin
            if (fit_found) begin
               occ_we          = 1'b1;
               hdr_we          = 1'b1;
               occ_wdata       = occ_rd | ((~(ALL_ONES << fit_len)) << fit_pos);
               hdr_wdata       = hdr_rd | (ONE_BIT << fit_pos);
               rsp_valid_in    = 1'b1;
               rsp_status_in   = ST_DONE;
               rsp_page_out_in = alloc_page[PAGE_W-1:0];
               state_in        = S_IDLE;
            end else if (cnt_last) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = ST_NO_ROOM;
               rsp_page_out_in = '0;
               state_in        = S_IDLE;
            end else begin
               cnt_in   = cnt_ff + AW'(1);
               rd_en    = 1'b1;
               rd_addr  = cnt_ff + AW'(1);
            end
         end

         S_FDIV: begin
            q_in     = quot_prod[SHIFT +: PAGE_W];
            state_in = S_FREAD;
         end

         S_FREAD: begin
            if (q_ff >= PAGE_W'(WORD_COUNT)) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = ST_NO_HEADER;
               rsp_page_out_in = '0;
               state_in        = S_IDLE;
            end else begin
               pos_in   = rem_full[PB-1:0];
               rd_en    = 1'b1;
               rd_addr  = q_ff[AW-1:0];
               state_in = S_FEVAL;
            end
         end

         S_FEVAL: begin
            wr_addr = q_ff[AW-1:0];
            if (!hdr_hit) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = ST_NO_HEADER;
               rsp_page_out_in = '0;
               state_in        = S_IDLE;
            end else begin
               occ_we          = 1'b1;
               hdr_we          = 1'b1;
               occ_wdata       = freed_occ;
               hdr_wdata       = hdr_rd & ~(ONE_BIT << hpos);
               rsp_page_out_in = free_page[PAGE_W-1:0];
               if (freed_occ != '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_FREED;
                  state_in      = S_IDLE;
               end else begin
                  // This word is empty; see whether every other word is too.
                  cnt_in   = '0;
                  state_in = S_FCHK;
               end
            end
         end

         S_FCHK: begin
            rd_en    = 1'b1;
            state_in = S_FCMP;
         end

         S_FCMP: begin
            if (occ_rd != '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FREED;
               state_in      = S_IDLE;
            end else if (cnt_last) begin
               cnt_in   = '0;
               state_in = S_FFILL;
            end else begin
               cnt_in   = cnt_ff + AW'(1);
               state_in = S_FCHK;
            end
         end

         // Whole region empty: mark every page taken, which retires it.
         S_FFILL: begin
            occ_we    = 1'b1;
            occ_wdata = ALL_ONES;
            if (cnt_last) begin
               cnt_in        = '0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_RETIRED;
               state_in      = S_IDLE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The reserved page count is taken whenever it is offered.
   always_comb begin
      reserved_in = reserved_ff;
      if (csr_valid) begin
         reserved_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         reserved_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         reserved_ff  <= reserved_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff         <= left_in;
      n_ff            <= n_in;
      page_ff         <= page_in;
      q_ff            <= q_in;
      pos_ff          <= pos_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_page_out_ff <= rsp_page_out_in;
   end

   assign busy         = (state_ff != S_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_page_out = rsp_page_out_ff;

`ifndef SYNTH
   // Every result is issued while the sequencer is idle.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while the sequencer is busy");

   // An accepted request either keeps the block busy or is answered at once.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither started nor answered");

   // An allocate of zero pages is refused straight away.
   a_alloc_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == REQ_ALLOC) && (req_span_pages == '0))
      |=> (rsp_valid && (rsp_status == ST_NO_ROOM) && (rsp_page_out == '0)))
      else $error("zero-page allocate not refused");
`endif

endmodule
